// File: src/dbd_pkg.sv
// Shared types and constants for the days-between-dates block.
`default_nettype none
package dbd_pkg;

   // Line layout
   localparam int unsigned SECOND_OFFSET = 13;
   localparam int unsigned LINE_BYTES    = 23;
   localparam int unsigned POS_MAX       = 31;
   localparam logic [7:0]  ASCII_ZERO    = 8'd48;

   // Field widths
   localparam int unsigned DAY_W   = 6;
   localparam int unsigned MONTH_W = 5;
   localparam int unsigned YEAR_W  = 14;
   localparam int unsigned POS_W   = 5;
   localparam int unsigned COUNT_W = 22;

   // Default queue depths
   localparam int unsigned JOB_DEPTH_DEF = 4;
   localparam int unsigned RSP_DEPTH_DEF = 8;

   typedef struct packed {
      logic [DAY_W-1:0]   day;
      logic [MONTH_W-1:0] month;
      logic [YEAR_W-1:0]  year;
   } date_type;

   // One parsed line, handed from the parser to the day arithmetic
   typedef struct packed {
      date_type first;
      date_type second;
   } job_type;

endpackage
`default_nettype wire

// File: src/days_between_dates.sv
// Top level of the days-between-dates block: parser, job queue, arithmetic, result queue.
//
//   channel | ports                                   | handshake
//   --------+-----------------------------------------+------------------------------
//   input   | req_char_in[7:0], req_line_end          | word taken on req_push && !req_full
//   result  | rsp_day_count[21:0]                     | word taken on rsp_pop && !rsp_empty
//
// While req_full is low one byte per cycle is accepted; a word with req_line_end set queues one job.
// A job waits in the job queue, then goes through three pipeline registers (year/month prep,
// constant multiplies, day-number sum); after the last of them its result is written into
// the result queue and shows on the result ports once it is at the head of that queue.
// Reset clears position, parsed fields and both queues; no clearing pass.
// A stalled result side fills the result queue, then the job queue, then raises req_full.
`default_nettype none
module days_between_dates #(
   parameter int unsigned JOB_DEPTH = dbd_pkg::JOB_DEPTH_DEF,
   parameter int unsigned RSP_DEPTH = dbd_pkg::RSP_DEPTH_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_push,
   output logic                               req_full,
   input  wire logic [7:0]                    req_char_in,
   input  wire logic                          req_line_end,
   output logic                               rsp_empty,
   input  wire logic                          rsp_pop,
   output logic [dbd_pkg::COUNT_W-1:0]        rsp_day_count
);

   localparam int unsigned JOB_W = $bits(dbd_pkg::job_type);

   logic                                 byte_valid;
   logic                                 job_push;
   dbd_pkg::job_type                     job_in, job_out;
   logic                                 job_full, job_empty, job_take;
   logic [$clog2(JOB_DEPTH+1)-1:0]       job_level;
   logic [$clog2(RSP_DEPTH+1)-1:0]       rsp_level;
   logic                                 res_push;
   logic [dbd_pkg::COUNT_W-1:0]          res_data;
   logic                                 rsp_full;

   // Hold off bytes while the job queue is full
   assign req_full   = job_full;
   assign byte_valid = req_push && !job_full;

   dbd_parse u_parse (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (byte_valid),
      .byte_char  (req_char_in),
      .byte_last  (req_line_end),
      .job_push   (job_push),
      .job_data   (job_in)
   );

   dbd_fifo #(
      .WIDTH (JOB_W),
      .DEPTH (JOB_DEPTH)
   ) u_job_q (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (job_in),
      .full      (job_full),
      .pop       (job_take),
      .pop_data  (job_out),
      .empty     (job_empty),
      .level     (job_level)
   );

   dbd_calc #(
      .RSP_DEPTH (RSP_DEPTH)
   ) u_calc (
      .clock     (clock),
      .reset     (reset),
      .job_ready (!job_empty && (job_level != '0)),
      .job_data  (job_out),
      .job_take  (job_take),
      .rsp_level (rsp_level),
      .res_push  (res_push),
      .res_data  (res_data)
   );

   dbd_fifo #(
      .WIDTH (dbd_pkg::COUNT_W),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_q (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push && !rsp_full),
      .push_data (res_data),
      .full      (rsp_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_day_count),
      .empty     (rsp_empty),
      .level     (rsp_level)
   );

endmodule
`default_nettype wire

// File: src/dbd_fifo.sv
// Small register-based FIFO used for the job queue and the result queue.
`default_nettype none
module dbd_fifo #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 4
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       push,
   input  wire logic [WIDTH-1:0]           push_data,
   output logic                            full,
   input  wire logic                       pop,
   output logic [WIDTH-1:0]                pop_data,
   output logic                            empty,
   output logic [$clog2(DEPTH+1)-1:0]      level
);

   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned LW = $clog2(DEPTH+1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [LW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == LW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign level    = count_ff;
   assign pop_data = mem_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH-1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH-1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + LW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - LW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage, no reset
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

// File: src/dbd_parse.sv
// Front end: takes line bytes, parses both dates by position, emits a job per line.
`default_nettype none
module dbd_parse (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                byte_valid,
   input  wire logic [7:0]          byte_char,
   input  wire logic                byte_last,
   output logic                     job_push,
   output dbd_pkg::job_type         job_data
);

   localparam int unsigned POS_W = dbd_pkg::POS_W;

   // Positions inside one date
   localparam logic [3:0] REL_DAY_TENS   = 4'd0;
   localparam logic [3:0] REL_DAY_UNITS  = 4'd1;
   localparam logic [3:0] REL_MON_TENS   = 4'd3;
   localparam logic [3:0] REL_MON_UNITS  = 4'd4;
   localparam logic [3:0] REL_YEAR_1000  = 4'd6;
   localparam logic [3:0] REL_YEAR_100   = 4'd7;
   localparam logic [3:0] REL_YEAR_10    = 4'd8;
   localparam logic [3:0] REL_YEAR_1     = 4'd9;

   logic [POS_W-1:0]  pos_ff, pos_in;
   dbd_pkg::date_type first_ff, first_in;
   dbd_pkg::date_type second_ff, second_in;
   dbd_pkg::date_type upd;
   logic              in_first, in_line;
   logic [3:0]        rel;
   // byte minus '0', wrapped at the widest field so non-digits fold in like the year math
   logic [dbd_pkg::YEAR_W-1:0] v;

   assign in_first = (pos_ff < POS_W'(dbd_pkg::SECOND_OFFSET));
   assign in_line  = (pos_ff < POS_W'(dbd_pkg::LINE_BYTES));
   assign rel      = in_first ? 4'(pos_ff) : 4'(pos_ff - POS_W'(dbd_pkg::SECOND_OFFSET));
   assign v        = dbd_pkg::YEAR_W'(byte_char) - dbd_pkg::YEAR_W'(dbd_pkg::ASCII_ZERO);

   // Apply this byte to the date it falls in
   always_comb begin
      upd = in_first ? first_ff : second_ff;
      unique case (rel)
         REL_DAY_TENS: begin
            if (byte_char == "1") begin
               upd.day = 6'd10;
            end else if (byte_char == "2") begin
               upd.day = 6'd20;
            end else if (byte_char == "3") begin
               upd.day = 6'd30;
            end else begin
               upd.day = 6'd0;
            end
         end
         REL_DAY_UNITS: upd.day   = upd.day + v[5:0];
         REL_MON_TENS:  upd.month = (byte_char == "1") ? 5'd10 : 5'd0;
         REL_MON_UNITS: upd.month = upd.month + v[4:0];
         REL_YEAR_1000: upd.year  = v * 14'd1000;
         REL_YEAR_100:  upd.year  = upd.year + v * 14'd100;
         REL_YEAR_10:   upd.year  = upd.year + v * 14'd10;
         REL_YEAR_1:    upd.year  = upd.year + v;
         default: ;
      endcase
   end

   // Next field and position values
   always_comb begin
      first_in  = first_ff;
      second_in = second_ff;
      pos_in    = pos_ff;
      if (byte_valid) begin
         if (in_line && in_first) begin
            first_in = upd;
         end else if (in_line) begin
            second_in = upd;
         end
         if (byte_last) begin
            pos_in = '0;
         end else if (pos_ff != POS_W'(dbd_pkg::POS_MAX)) begin
            pos_in = pos_ff + POS_W'(1);
         end
      end
   end

   assign job_push       = byte_valid && byte_last;
   assign job_data.first  = first_in;
   assign job_data.second = second_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         first_ff  <= '0;
         second_ff <= '0;
      end else begin
         pos_ff    <= pos_in;
         first_ff  <= first_in;
         second_ff <= second_in;
      end
   end

endmodule
`default_nettype wire

// File: src/dbd_calc.sv
// Back end: three-stage day-number pipeline and the gap between the two dates, less one.
`default_nettype none
module dbd_calc #(
   parameter int unsigned RSP_DEPTH = dbd_pkg::RSP_DEPTH_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               job_ready,
   input  wire dbd_pkg::job_type                   job_data,
   output logic                                    job_take,
   input  wire logic [$clog2(RSP_DEPTH+1)-1:0]     rsp_level,
   output logic                                    res_push,
   output logic [dbd_pkg::COUNT_W-1:0]             res_data
);

   localparam int unsigned LW = $clog2(RSP_DEPTH+1);
   localparam int unsigned SW = ((LW > 2) ? LW : 2) + 1;
   localparam int unsigned DN_W = 23;

   // Stage 1: shifted year, month index term input, day
   typedef struct packed {
      logic [14:0] yy;
      logic [12:0] mterm;
      logic [5:0]  day;
   } s1_type;

   // Stage 2: products
   typedef struct packed {
      logic [DN_W-1:0] y365;
      logic [12:0]     q;
      logic [7:0]      cent;
      logic [9:0]      mdays;
      logic [5:0]      day;
   } s2_type;

   function automatic s1_type prep(input dbd_pkg::date_type dt);
      s1_type r;
      logic   early;
      logic [5:0] mp;
      early   = (dt.month <= 5'd2);
      mp      = early ? 6'(dt.month) + 6'd9 : 6'(dt.month) - 6'd3;
      r.yy    = 15'(dt.year) + 15'd400 - (early ? 15'd1 : 15'd0);
      r.mterm = 13'(mp) * 13'd153 + 13'd2;
      r.day   = dt.day;
      return r;
   endfunction

   // floor(yy/100) = floor(floor(yy/4)/25), by reciprocal 41944/2^20
   function automatic s2_type mult(input s1_type a);
      s2_type r;
      logic [28:0] qm;
      logic [25:0] mm;
      r.y365  = DN_W'(a.yy) * DN_W'(365);
      r.q     = a.yy[14:2];
      qm      = 29'(r.q) * 29'd41944;
      r.cent  = qm[27:20];
      mm      = 26'(a.mterm) * 26'd6554;
      r.mdays = mm[24:15];
      r.day   = a.day;
      return r;
   endfunction

   function automatic logic [DN_W-1:0] total(input s2_type a);
      return a.y365 + DN_W'(a.q) - DN_W'(a.cent) + DN_W'(a.cent[7:2])
             + DN_W'(a.mdays) + DN_W'(a.day);
   endfunction

   logic            v1_ff, v2_ff, v3_ff;
   s1_type          a1_ff, b1_ff;
   s2_type          a2_ff, b2_ff;
   logic [DN_W-1:0] a3_ff, b3_ff;
   logic [SW-1:0]   committed;
   logic [DN_W-1:0] diff;

   // Issue only when the result queue has room for everything in flight
   assign committed = SW'(rsp_level) + SW'(v1_ff) + SW'(v2_ff) + SW'(v3_ff);
   assign job_take  = job_ready && (committed < SW'(RSP_DEPTH));

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= job_take;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   // Datapath, no reset
   always_ff @(posedge clock) begin
      a1_ff <= prep(job_data.first);
      b1_ff <= prep(job_data.second);
      a2_ff <= mult(a1_ff);
      b2_ff <= mult(b1_ff);
      a3_ff <= total(a2_ff);
      b3_ff <= total(b2_ff);
   end

   // Absolute gap minus one, floored at zero
   assign diff     = (a3_ff > b3_ff) ? a3_ff - b3_ff : b3_ff - a3_ff;
   assign res_push = v3_ff;
   assign res_data = (diff != '0) ? dbd_pkg::COUNT_W'(diff - DN_W'(1)) : '0;

endmodule
`default_nettype wire
